// ----- rtl/core/jlms_pkg.sv -----
`default_nettype none

package jlms_pkg;

    // Header field widths.
    localparam int unsigned ByteW   = 8;
    localparam int unsigned HlenW   = 16;
    localparam int unsigned PosW    = 17;
    localparam int unsigned OffsetW = 18;

    // Reset value of the header length register.
    localparam logic [HlenW-1:0] HlenReset = 16'd1024;

    // Shortest header that can be taken as JPEG.
    localparam logic [HlenW-1:0] MinHeaderLen = 16'd10;

    // Marker prefix, signature and start-of-scan codes.
    localparam logic [ByteW-1:0] MarkerPrefix = 8'hFF;
    localparam logic [ByteW-1:0] SoiCode      = 8'hD8;
    localparam logic [ByteW-1:0] SosCode      = 8'hDA;

    // Lossless and JPEG-LS frame marker codes.
    localparam logic [ByteW-1:0] SofLsCode = 8'hF7;
    localparam logic [ByteW-1:0] LseCode   = 8'hF8;
    localparam logic [ByteW-1:0] Sof3Code  = 8'hC3;
    localparam logic [ByteW-1:0] Sof7Code  = 8'hC7;
    localparam logic [ByteW-1:0] Sof11Code = 8'hCB;
    localparam logic [ByteW-1:0] Sof15Code = 8'hCF;

    // Offset of the first marker prefix and the margin at the end of the header.
    localparam logic [OffsetW-1:0] FirstMarkerOffset = 18'd2;
    localparam logic [OffsetW:0]   TailMargin        = 19'd4;

    // Scan phase.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SOI    = 3'd1,
        PH_SKIP   = 3'd2,
        PH_MARKER = 3'd3,
        PH_LENHI  = 3'd4,
        PH_LENLO  = 3'd5,
        PH_DONE   = 3'd7
    } t_phase;

    // One verdict per header.
    typedef struct packed {
        logic looks_like_jpeg;
        logic lossless;
    } t_verdict;

    // Verdict from the scanner to the output buffer.
    typedef struct packed {
        logic     valid;
        t_verdict verdict;
    } t_result;

    // Lossless and JPEG-LS frame markers.
    function automatic logic is_lossless_marker(input logic [ByteW-1:0] m);
        return (m == SofLsCode) || (m == LseCode) || (m == Sof3Code) ||
               (m == Sof7Code) || (m == Sof11Code) || (m == Sof15Code);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jlms_byte_if.sv -----
`default_nettype none

interface jlms_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/jlms_verdict_if.sv -----
`default_nettype none

interface jlms_verdict_if;
    logic valid;
    logic ready;
    logic looks_like_jpeg;
    logic lossless;

    modport source (output valid, output looks_like_jpeg, output lossless, input ready);
    modport sink   (input valid, input looks_like_jpeg, input lossless, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/jpeg_lossless_marker_scanner_top.sv -----
`default_nettype none

// Channel     Dir  Payload                         Transfer
// i_byte      in   data_byte[7:0], first           valid && ready
// o_verdict   out  looks_like_jpeg, lossless       valid && ready
// i_cfg_*     in   header_length[15:0]             i_cfg_wr_en high
//
// One header byte is taken every cycle; the scanner updates its phase,
// position and next marker offset in the same cycle. Verdicts are registered
// in a two-slot output buffer, so bytes keep flowing while one
// verdict is held; the input stalls only when two verdicts are waiting.
// Reset sets header_length to 1024, puts the scanner in idle and empties the
// buffer. No clearing pass is needed.

module jpeg_lossless_marker_scanner_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [jlms_pkg::HlenW-1:0] i_cfg_wr_data,
    jlms_byte_if.sink                       i_byte,
    jlms_verdict_if.source                  o_verdict
);
    import jlms_pkg::*;

    logic [HlenW-1:0] r_header_length;
    logic             space;
    logic             accept;
    t_result          result;

    // Header length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length <= HlenReset;
        end else if (i_cfg_wr_en) begin
            r_header_length <= i_cfg_wr_data;
        end
    end

    // Input transfer.
    assign i_byte.ready = space;
    assign accept       = i_byte.valid && space;

    jlms_scan u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_header_length (r_header_length),
        .i_accept        (accept),
        .i_data_byte     (i_byte.data_byte),
        .i_first         (i_byte.first),
        .o_result        (result)
    );

    jlms_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_result  (result),
        .o_space   (space),
        .o_verdict (o_verdict)
    );

endmodule

`default_nettype wire

// ----- rtl/core/jlms_scan.sv -----
`default_nettype none

module jlms_scan (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [jlms_pkg::HlenW-1:0]   i_header_length,
    input  wire logic                         i_accept,
    input  wire logic [jlms_pkg::ByteW-1:0]   i_data_byte,
    input  wire logic                         i_first,
    output jlms_pkg::t_result                 o_result
);
    import jlms_pkg::*;

    t_phase              r_phase, n_phase;
    logic [PosW-1:0]     r_position, n_position;
    logic [OffsetW-1:0]  r_next_offset, n_next_offset;
    logic [ByteW-1:0]    r_length_high, n_length_high;

    logic [PosW-1:0]     pos_inc;
    logic [HlenW-1:0]    seg_len;
    logic [OffsetW-1:0]  offset_sum;
    logic                seg_short;
    logic                past_end;
    logic                at_marker;
    logic                scan_active;
    logic                short_header;

    // Shared datapath: position step, segment length and next marker offset.
    assign pos_inc      = r_position + 1'b1;
    assign seg_len      = {r_length_high, i_data_byte};
    assign offset_sum   = r_next_offset + FirstMarkerOffset + {2'b00, seg_len};
    assign seg_short    = seg_len < 16'd2;
    assign past_end     = ({1'b0, offset_sum} + TailMargin) >= {3'b000, i_header_length};
    assign at_marker    = {1'b0, pos_inc} == r_next_offset;
    assign short_header = i_header_length < MinHeaderLen;
    assign scan_active  = (r_phase == PH_SOI) || (r_phase == PH_SKIP) ||
                          (r_phase == PH_MARKER) || (r_phase == PH_LENHI) ||
                          (r_phase == PH_LENLO);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_first) begin
                if (short_header || (i_data_byte != MarkerPrefix)) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_SOI;
                end
            end else begin
                case (r_phase)
                    PH_IDLE: n_phase = PH_IDLE;
                    PH_DONE: n_phase = PH_DONE;
                    PH_SOI: begin
                        if (pos_inc == 17'd1) begin
                            n_phase = (i_data_byte != SoiCode) ? PH_DONE : PH_SOI;
                        end else begin
                            n_phase = (i_data_byte != MarkerPrefix) ? PH_DONE : PH_MARKER;
                        end
                    end
                    PH_MARKER: begin
                        if ((i_data_byte == SosCode) || is_lossless_marker(i_data_byte)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_LENHI;
                        end
                    end
                    PH_LENHI: n_phase = PH_LENLO;
                    PH_LENLO: n_phase = (seg_short || past_end) ? PH_DONE : PH_SKIP;
                    PH_SKIP: begin
                        if (at_marker) begin
                            n_phase = (i_data_byte != MarkerPrefix) ? PH_DONE : PH_MARKER;
                        end
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
        end
    end

    // Verdict and datapath register updates.
    always_comb begin
        n_position    = r_position;
        n_next_offset = r_next_offset;
        n_length_high = r_length_high;
        o_result      = '0;
        if (i_accept) begin
            if (i_first) begin
                n_position    = '0;
                n_next_offset = FirstMarkerOffset;
                n_length_high = '0;
            end else if (scan_active) begin
                n_position = pos_inc;
                if (r_phase == PH_LENHI) begin
                    n_length_high = i_data_byte;
                end
                if ((r_phase == PH_LENLO) && !seg_short) begin
                    n_next_offset = offset_sum;
                end
            end
            // A verdict falls on a failing first byte or on the byte that moves a live scan to done.
            o_result.valid = (n_phase == PH_DONE) && (i_first || scan_active);
            o_result.verdict.looks_like_jpeg = !i_first && (r_phase != PH_SOI);
            o_result.verdict.lossless = !i_first && (r_phase == PH_MARKER) &&
                                        is_lossless_marker(i_data_byte);
        end
    end

    // Control state and datapath registers all take their reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_position    <= '0;
            r_next_offset <= FirstMarkerOffset;
            r_length_high <= '0;
        end else begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_next_offset <= n_next_offset;
            r_length_high <= n_length_high;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/jlms_out_buf.sv -----
`default_nettype none

module jlms_out_buf (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire jlms_pkg::t_result i_result,
    output logic             o_space,
    jlms_verdict_if.source   o_verdict
);
    import jlms_pkg::*;

    logic     r_main_valid, n_main_valid;
    logic     r_skid_valid, n_skid_valid;
    t_verdict r_main, n_main;
    t_verdict r_skid, n_skid;
    logic     pop;

    // Room for one more verdict as long as the skid slot is free.
    assign o_space = !r_skid_valid;
    assign pop     = r_main_valid && o_verdict.ready;

    // Main slot refills from the skid slot first, then from a new verdict.
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                n_main_valid = 1'b1;
                n_main       = r_skid;
                n_skid_valid = i_result.valid;
                n_skid       = i_result.verdict;
            end else begin
                n_main_valid = i_result.valid;
                n_main       = i_result.verdict;
            end
        end else if (i_result.valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result.verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    // Result channel.
    assign o_verdict.valid           = r_main_valid;
    assign o_verdict.looks_like_jpeg = r_main.looks_like_jpeg;
    assign o_verdict.lossless        = r_main.lossless;

endmodule

`default_nettype wire
